[hdl/ckap_pkg.sv]
// Package for the chroma-key alpha pixel unit: beat types, register
// indexes, register reset values and widths. No dependencies.
`default_nettype none

package ckap_pkg;

  // Widest configuration register (luma window)
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE              = 4'd0,
    REG_ALPHA_SCALE       = 4'd1,
    REG_LUMA_WINDOW       = 4'd2,
    REG_KEY_DIRECTION     = 4'd3,
    REG_KEY_MAGNITUDE     = 4'd4,
    REG_ANGLE_SLOPES      = 4'd5,
    REG_SUPPRESSION_GAINS = 4'd6,
    REG_NOISE_SQ          = 4'd7
  } cfg_reg_t;

  localparam logic        RST_MODE              = 1'b0;
  localparam logic [8:0]  RST_ALPHA_SCALE       = 9'd256;
  localparam logic [17:0] RST_LUMA_WINDOW       = 18'd116764;
  localparam logic [15:0] RST_KEY_DIRECTION     = 16'd40370;
  localparam logic [6:0]  RST_KEY_MAGNITUDE     = 7'd119;
  localparam logic [15:0] RST_ANGLE_SLOPES      = 16'd10501;
  localparam logic [15:0] RST_SUPPRESSION_GAINS = 16'd4096;
  localparam logic [12:0] RST_NOISE_SQ          = 13'd4;

  // Full alpha gain
  localparam logic [8:0] GAIN_UNITY = 9'd256;

  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_luma;
    logic [7:0] in_cb;
    logic [7:0] in_cr;
    logic       frame_end;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_luma;
    logic [7:0] out_cb;
    logic [7:0] out_cr;
    logic       out_frame_end;
  } pixel_out_t;

endpackage

`default_nettype wire

[hdl/chroma_key_alpha_pixel_unit.sv]
// Chroma-key alpha pixel unit: five-stage pipeline, one AYUV pixel per beat.
// An accepted input beat moves through the stage 1 to 4 registers into the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// beat is stalled, so the output register sets the rate.
// Reset: synchronous, active high; clears valid bits and loads register defaults.
// Depends on ckap_pkg.
`default_nettype none

module chroma_key_alpha_pixel_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                src_valid,
  output logic                               src_stall,
  input  wire  ckap_pkg::pixel_in_t          src_data,
  output logic                               dst_valid,
  input  wire                                dst_stall,
  output ckap_pkg::pixel_out_t               dst_data,
  input  wire                                cfg_we,
  input  wire  [ckap_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [ckap_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ckap_pkg::*;

  function automatic logic signed [7:0] sat_s8(input logic signed [17:0] v);
    if (v > 18'sd127) begin
      return 8'sd127;
    end else if (v < -18'sd128) begin
      return -8'sd128;
    end
    return v[7:0];
  endfunction

  // Configuration registers
  logic        mode;
  logic [8:0]  alpha_scale;
  logic [17:0] luma_window;
  logic [15:0] key_direction;
  logic [6:0]  key_magnitude;
  logic [15:0] angle_slopes;
  logic [15:0] suppression_gains;
  logic [12:0] noise_sq;

  // Take register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= RST_MODE;
      alpha_scale       <= RST_ALPHA_SCALE;
      luma_window       <= RST_LUMA_WINDOW;
      key_direction     <= RST_KEY_DIRECTION;
      key_magnitude     <= RST_KEY_MAGNITUDE;
      angle_slopes      <= RST_ANGLE_SLOPES;
      suppression_gains <= RST_SUPPRESSION_GAINS;
      noise_sq          <= RST_NOISE_SQ;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:              mode              <= cfg_data[0];
        REG_ALPHA_SCALE:       alpha_scale       <= cfg_data[8:0];
        REG_LUMA_WINDOW:       luma_window       <= cfg_data[17:0];
        REG_KEY_DIRECTION:     key_direction     <= cfg_data[15:0];
        REG_KEY_MAGNITUDE:     key_magnitude     <= cfg_data[6:0];
        REG_ANGLE_SLOPES:      angle_slopes      <= cfg_data[15:0];
        REG_SUPPRESSION_GAINS: suppression_gains <= cfg_data[15:0];
        REG_NOISE_SQ:          noise_sq          <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Register fields
  logic signed [7:0] key_cb, key_cr;
  logic [8:0]        luma_min, luma_max;
  logic [7:0]        tan15, cot15, inv_kc_gain, spill_scale;
  logic [8:0]        gain;

  assign key_cb      = $signed(key_direction[7:0]);
  assign key_cr      = $signed(key_direction[15:8]);
  assign luma_min    = luma_window[8:0];
  assign luma_max    = luma_window[17:9];
  assign tan15       = angle_slopes[7:0];
  assign cot15       = angle_slopes[15:8];
  assign inv_kc_gain = suppression_gains[7:0];
  assign spill_scale = suppression_gains[15:8];
  assign gain        = (alpha_scale > GAIN_UNITY) ? GAIN_UNITY : alpha_scale;

  // Whole pipeline moves unless the output beat is held
  logic advance;
  assign advance   = !dst_valid || !dst_stall;
  assign src_stall = !advance;

  // ---------------- Stage 1: alpha gain, chroma products, luma window
  logic              v1;
  logic [7:0]        a1, y1, cbr1, crr1;
  logic              fe1, key1;
  logic signed [15:0] p_ub1, p_vr1, p_vb1, p_ur1;

  logic signed [7:0] u0, w0;
  logic [16:0]       ag0;
  assign u0  = $signed({~src_data.in_cb[7], src_data.in_cb[6:0]});
  assign w0  = $signed({~src_data.in_cr[7], src_data.in_cr[6:0]});
  assign ag0 = src_data.in_alpha * gain;

  always_ff @(posedge clk) begin
    if (advance) begin
      a1    <= ag0[15:8];
      y1    <= src_data.in_luma;
      cbr1  <= src_data.in_cb;
      crr1  <= src_data.in_cr;
      fe1   <= src_data.frame_end;
      key1  <= mode && ({1'b0, src_data.in_luma} >= luma_min)
                    && ({1'b0, src_data.in_luma} <= luma_max);
      p_ub1 <= u0 * key_cb;
      p_vr1 <= w0 * key_cr;
      p_vb1 <= w0 * key_cb;
      p_ur1 <= u0 * key_cr;
    end
  end

  // ---------------- Stage 2: rotate into key axes
  logic              v2;
  logic [7:0]        a2, y2, cbr2, crr2;
  logic              fe2, key2;
  logic signed [7:0] x2, z2;

  logic signed [17:0] sx1, sz1;
  assign sx1 = 18'(p_ub1) + 18'(p_vr1);
  assign sz1 = 18'(p_vb1) - 18'(p_ur1);

  always_ff @(posedge clk) begin
    if (advance) begin
      a2   <= a1;
      y2   <= y1;
      cbr2 <= cbr1;
      crr2 <= crr1;
      fe2  <= fe1;
      key2 <= key1;
      x2   <= sat_s8(sx1 >>> 7);
      z2   <= sat_s8(sz1 >>> 7);
    end
  end

  // ---------------- Stage 3: accept-angle wedge, foreground distance
  logic              v3;
  logic [7:0]        a3, y3, cbr3, crr3;
  logic              fe3, wedge3;
  logic signed [7:0] x3, z3;
  logic [8:0]        x1_3;
  logic signed [8:0] dx3;

  logic signed [16:0] xt2, zc2;
  logic signed [12:0] bound2;
  logic signed [7:0]  t2;
  logic [8:0]         az2;
  assign xt2    = x2 * $signed({1'b0, tan15});
  assign zc2    = z2 * $signed({1'b0, cot15});
  assign bound2 = (xt2 >>> 4) > 17'sd127 ? 13'sd127 : 13'(xt2 >>> 4);
  assign t2     = sat_s8(18'(zc2 >>> 4));
  assign az2    = z2[7] ? 9'(-10'(z2)) : {1'b0, z2};

  always_ff @(posedge clk) begin
    if (advance) begin
      a3     <= a2;
      y3     <= y2;
      cbr3   <= cbr2;
      crr3   <= crr2;
      fe3    <= fe2;
      wedge3 <= key2 && ($signed({4'b0, az2}) <= bound2);
      x3     <= x2;
      z3     <= z2;
      x1_3   <= t2[7] ? 9'(-10'(t2)) : {1'b0, t2};
      dx3    <= 9'(x2) - $signed({2'b0, key_magnitude});
    end
  end

  // ---------------- Stage 4: alpha cut, spill, rebuild and distance products
  logic               v4;
  logic [7:0]         a4, y4, cbr4, crr4, cut4, spill4;
  logic               fe4, wedge4;
  logic signed [17:0] p_xb4, p_zr4, p_xr4, p_zb4;
  logic [16:0]        dist4;

  logic signed [9:0]  d3;
  logic [6:0]         dc3;
  logic [14:0]        cp3, sp3;
  logic signed [9:0]  x1s3;
  logic signed [17:0] dd3;
  logic signed [15:0] zz3;
  assign d3   = 10'(x3) - $signed({1'b0, x1_3});
  assign dc3  = d3[9] ? 7'd0 : d3[6:0];
  assign cp3  = dc3 * inv_kc_gain;
  assign sp3  = dc3 * spill_scale;
  assign x1s3 = $signed({1'b0, x1_3});
  assign dd3  = dx3 * dx3;
  assign zz3  = z3 * z3;

  always_ff @(posedge clk) begin
    if (advance) begin
      a4     <= a3;
      y4     <= y3;
      cbr4   <= cbr3;
      crr4   <= crr3;
      fe4    <= fe3;
      wedge4 <= wedge3;
      cut4   <= (cp3[14:1] > 14'd255) ? 8'd255 : cp3[8:1];
      spill4 <= (sp3[14:4] > 11'd255) ? 8'd255 : sp3[11:4];
      p_xb4  <= x1s3 * key_cb;
      p_zr4  <= z3 * key_cr;
      p_xr4  <= x1s3 * key_cr;
      p_zb4  <= z3 * key_cb;
      dist4  <= dd3[16:0] + 17'(zz3[14:0]);
    end
  end

  // ---------------- Stage 5: final alpha, luma and chroma
  logic [15:0]        ab4;
  logic [7:0]         alpha4, luma4;
  logic signed [17:0] su4, sv4;
  logic signed [7:0]  uo4, vo4;
  logic [7:0]         inv_cut4;
  assign inv_cut4 = 8'd255 - cut4;
  assign ab4      = a4 * inv_cut4;
  assign su4      = p_xb4 - p_zr4;
  assign sv4      = p_xr4 + p_zb4;
  assign uo4      = sat_s8(su4 >>> 7);
  assign vo4      = sat_s8(sv4 >>> 7);
  assign alpha4   = (dist4 < {4'b0, noise_sq}) ? 8'd0 : ab4[15:8];
  assign luma4    = (spill4 > y4) ? 8'd0 : y4 - spill4;

  always_ff @(posedge clk) begin
    if (advance) begin
      dst_data.out_frame_end <= fe4;
      if (wedge4) begin
        dst_data.out_alpha <= alpha4;
        dst_data.out_luma  <= luma4;
        dst_data.out_cb    <= {~uo4[7], uo4[6:0]};
        dst_data.out_cr    <= {~vo4[7], vo4[6:0]};
      end else begin
        dst_data.out_alpha <= a4;
        dst_data.out_luma  <= y4;
        dst_data.out_cb    <= cbr4;
        dst_data.out_cr    <= crr4;
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      dst_valid <= 1'b0;
    end else if (advance) begin
      v1        <= src_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      dst_valid <= v4;
    end
  end

`ifndef SYNTHESIS
  // A pixel in the last stage reaches the output when the pipe moves
  a_valid_travel: assert property (@(posedge clk) disable iff (rst)
    advance && v4 |=> dst_valid)
    else $error("last-stage pixel did not reach output");

  // Pixels outside the wedge leave luma untouched
  a_pass_luma: assert property (@(posedge clk) disable iff (rst)
    advance && v4 && !wedge4 |=> dst_data.out_luma == $past(y4))
    else $error("luma changed outside keyed wedge");

  // Keying only ever lowers the scaled alpha
  a_alpha_bound: assert property (@(posedge clk) disable iff (rst)
    advance && v4 |=> dst_data.out_alpha <= $past(a4))
    else $error("output alpha above scaled alpha");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for chroma_key_alpha_pixel_unit: a directed table, then
// random keying setups, with every output beat checked against its typed or predicted pixel.
// Depends on ckap_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
  import ckap_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 112;
  localparam int DRAIN       = 12;

  // Indexes past the register map; writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_LO = 4'd8;
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_HI = 4'd15;

  typedef enum {ROW_CFG, ROW_PIX, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    pixel_in_t              px;
    pixel_out_t             want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   src_valid = 1'b0;
  logic                   src_stall;
  pixel_in_t              src_data = '0;
  logic                   dst_valid;
  logic                   dst_stall = 1'b0;
  pixel_out_t             dst_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the unit's registers
  logic        mode_r    = RST_MODE;
  logic [8:0]  scale_r   = RST_ALPHA_SCALE;
  logic [17:0] window_r  = RST_LUMA_WINDOW;
  logic [15:0] keydir_r  = RST_KEY_DIRECTION;
  logic [6:0]  keymag_r  = RST_KEY_MAGNITUDE;
  logic [15:0] slopes_r  = RST_ANGLE_SLOPES;
  logic [15:0] gains_r   = RST_SUPPRESSION_GAINS;
  logic [12:0] noise_r   = RST_NOISE_SQ;

  pixel_out_t due_pixels[$];
  row_t       plan[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         quiet = 1'b0;

  chroma_key_alpha_pixel_unit dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Predict the output beat for one pixel under the shadow registers
  function automatic pixel_out_t key_pixel(input pixel_in_t px);
    int ain, y, u, v, gain, a, b, smin, smax, kcb, kcr, tg, ctg, okc, ksc;
    int x, z, bound, az, t, x1, d, cut, spill, dx, dist_sq;
    pixel_out_t r;
    ain  = int'(px.in_alpha);
    y    = int'(px.in_luma);
    u    = int'(px.in_cb) - 128;
    v    = int'(px.in_cr) - 128;
    gain = (scale_r > 9'd256) ? 256 : int'(scale_r);
    a    = (ain * gain) >>> 8;
    b    = a;
    if (mode_r) begin
      smin = int'(window_r[8:0]);
      smax = int'(window_r[17:9]);
      if (y >= smin && y <= smax) begin
        kcb = int'($signed(keydir_r[7:0]));
        kcr = int'($signed(keydir_r[15:8]));
        tg  = int'(slopes_r[7:0]);
        ctg = int'(slopes_r[15:8]);
        okc = int'(gains_r[7:0]);
        ksc = int'(gains_r[15:8]);
        // rotate chroma into key-aligned axes
        x = clamp((u * kcb + v * kcr) >>> 7, -128, 127);
        z = clamp((v * kcb - u * kcr) >>> 7, -128, 127);
        bound = (x * tg) >>> 4;
        if (bound > 127) bound = 127;
        az = (z < 0) ? -z : z;
        if (az <= bound) begin
          t  = clamp((z * ctg) >>> 4, -128, 127);
          x1 = (t < 0) ? -t : t;
          d  = x - x1;
          if (d < 0) d = 0;
          cut = (d * okc) / 2;
          if (cut > 255) cut = 255;
          b = (a * (255 - cut)) >>> 8;
          spill = (d * ksc) >>> 4;
          if (spill > 255) spill = 255;
          y = y - spill;
          if (y < 0) y = 0;
          u = clamp((x1 * kcb - z * kcr) >>> 7, -128, 127);
          v = clamp((x1 * kcr + z * kcb) >>> 7, -128, 127);
          // force transparency inside the noise circle
          dx      = x - int'(keymag_r);
          dist_sq = z * z + dx * dx;
          if (dist_sq > 32'hffff) dist_sq = 32'hffff;
          if (dist_sq < int'(noise_r)) b = 0;
        end
      end
    end
    r.out_alpha     = b[7:0];
    r.out_luma      = y[7:0];
    r.out_cb        = 8'(u + 128);
    r.out_cr        = 8'(v + 128);
    r.out_frame_end = px.frame_end;
    return r;
  endfunction

  function automatic void plan_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, val: val, px: '0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_pix(input pixel_in_t px);
    row_t r;
    r = '{kind: ROW_PIX, idx: '0, val: '0, px: px, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_typed(input pixel_in_t px, input pixel_out_t want);
    row_t r;
    r = '{kind: ROW_TYPED, idx: '0, val: '0, px: px, want: want};
    plan.push_back(r);
  endfunction

  // Write one register while the unit is idle; call at a falling edge
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_MODE:              mode_r   = val[0];
      REG_ALPHA_SCALE:       scale_r  = val[8:0];
      REG_LUMA_WINDOW:       window_r = val[17:0];
      REG_KEY_DIRECTION:     keydir_r = val[15:0];
      REG_KEY_MAGNITUDE:     keymag_r = val[6:0];
      REG_ANGLE_SLOPES:      slopes_r = val[15:0];
      REG_SUPPRESSION_GAINS: gains_r  = val[15:0];
      REG_NOISE_SQ:          noise_r  = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid and wait until every expected beat has come out
  task automatic settle();
    src_valid = 1'b0;
    while (due_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 11) == 0) begin
      src_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // Offer one beat, hold it until accepted, queue its expectation
  task automatic push_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
    src_valid = 1'b1;
    src_data  = px;
    do @(posedge clk); while (src_stall);
    due_pixels.push_back(typed ? want : key_pixel(px));
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_direction();
    logic [31:0] rnd;
    rnd = $urandom();
    case ($urandom_range(0, 8))
      0: return 16'h007f;          // +Cb
      1: return 16'h7f00;          // +Cr
      2: return 16'h0081;          // -Cb
      3: return 16'h8100;          // -Cr
      4: return 16'h5a5a;
      5: return 16'h5aa6;
      6: return RST_KEY_DIRECTION;
      7: return 16'ha65a;
      default: return rnd[15:0];   // not a unit vector
    endcase
  endfunction

  // Load a full register setup for one random phase
  task automatic setup_phase(input int phase);
    logic [31:0] rnd;
    logic [8:0]  lo, hi;
    rnd = $urandom();
    if (phase == 0) begin
      // every register at the top of its width
      write_reg(REG_MODE, 18'd1);
      write_reg(REG_ALPHA_SCALE, 18'h1ff);
      write_reg(REG_LUMA_WINDOW, 18'h3ffff);
      write_reg(REG_KEY_DIRECTION, 18'hffff);
      write_reg(REG_KEY_MAGNITUDE, 18'h7f);
      write_reg(REG_ANGLE_SLOPES, 18'hffff);
      write_reg(REG_SUPPRESSION_GAINS, 18'hffff);
      write_reg(REG_NOISE_SQ, 18'h1fff);
    end else if (phase == 1) begin
      write_reg(REG_MODE, 18'd1);
      write_reg(REG_ALPHA_SCALE, '0);
      write_reg(REG_LUMA_WINDOW, '0);
      write_reg(REG_KEY_DIRECTION, '0);
      write_reg(REG_KEY_MAGNITUDE, '0);
      write_reg(REG_ANGLE_SLOPES, '0);
      write_reg(REG_SUPPRESSION_GAINS, '0);
      write_reg(REG_NOISE_SQ, '0);
    end else begin
      write_reg(REG_MODE, (phase % 4 == 3) ? 18'd0 : 18'd1);
      case ($urandom_range(0, 3))
        0: write_reg(REG_ALPHA_SCALE, CFG_DATA_W'(GAIN_UNITY));
        1: write_reg(REG_ALPHA_SCALE, CFG_DATA_W'($urandom_range(0, 256)));
        2: write_reg(REG_ALPHA_SCALE, CFG_DATA_W'($urandom_range(257, 511)));
        default: write_reg(REG_ALPHA_SCALE, CFG_DATA_W'($urandom_range(128, 256)));
      endcase
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_LUMA_WINDOW, rnd[17:0]);
      end else begin
        lo = 9'($urandom_range(0, 60));
        hi = 9'($urandom_range(150, 300));
        write_reg(REG_LUMA_WINDOW, {hi, lo});
      end
      write_reg(REG_KEY_DIRECTION, CFG_DATA_W'(pick_direction()));
      write_reg(REG_KEY_MAGNITUDE, CFG_DATA_W'($urandom_range(0, 127)));
      rnd = $urandom();
      write_reg(REG_ANGLE_SLOPES, CFG_DATA_W'(rnd[15:0]));
      write_reg(REG_SUPPRESSION_GAINS, CFG_DATA_W'(rnd[31:16]));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_NOISE_SQ, CFG_DATA_W'($urandom_range(0, 8191)));
      end else begin
        write_reg(REG_NOISE_SQ, CFG_DATA_W'($urandom_range(0, 400)));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_INDEX_W'(IDX_UNUSED_LO + $urandom_range(0, 7)), rnd[17:0]);
      end
    end
  endtask

  // Mostly pixels near the key axis inside the luma window, some pure noise
  function automatic pixel_in_t make_pixel();
    logic [31:0] rnd;
    int kcb, kcr, r, p, s, du, dv, u, v, lo, hi;
    pixel_in_t px;
    rnd = $urandom();
    px  = {rnd, 1'b0};
    px.frame_end = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 3) == 0) return px;
    kcb = int'($signed(keydir_r[7:0]));
    kcr = int'($signed(keydir_r[15:8]));
    r   = $urandom_range(0, 140);
    p   = $urandom_range(0, 60);
    p   = p - 30;
    s   = ($urandom_range(0, 3) == 0) ? 3 : 0;
    du  = $urandom_range(0, 2 * s);
    dv  = $urandom_range(0, 2 * s);
    u   = clamp((kcb * r - kcr * p) / 127 + du - s, -128, 127);
    v   = clamp((kcr * r + kcb * p) / 127 + dv - s, -128, 127);
    px.in_cb = 8'(u + 128);
    px.in_cr = 8'(v + 128);
    lo = int'(window_r[8:0]);
    hi = (window_r[17:9] > 9'd255) ? 255 : int'(window_r[17:9]);
    if (lo <= hi) px.in_luma = 8'($urandom_range(lo, hi));
    return px;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (due_pixels.size() == 0) begin
        $error("out beat with nothing expected: %h", dst_data);
        mismatches++;
      end else begin
        want = due_pixels.pop_front();
        check_field("out_alpha", want.out_alpha, dst_data.out_alpha);
        check_field("out_luma", want.out_luma, dst_data.out_luma);
        check_field("out_cb", want.out_cb, dst_data.out_cb);
        check_field("out_cr", want.out_cr, dst_data.out_cr);
        check_field("out_frame_end", {7'd0, want.out_frame_end},
                    {7'd0, dst_data.out_frame_end});
      end
    end
  end

  // Output back-pressure in bursts
  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        dst_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        dst_stall = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int   i, phase, n;
    row_t row;

    // Reset values: clear mode passes the pixel through at unity gain
    plan_typed({8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, {8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    plan_typed({8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, {8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    plan_typed({8'haa, 8'h55, 8'h0f, 8'hf0, 1'b1}, {8'haa, 8'h55, 8'h0f, 8'hf0, 1'b1});
    plan_cfg(REG_ALPHA_SCALE, 18'd0);
    plan_typed({8'd255, 8'd77, 8'd128, 8'd128, 1'b0}, {8'd0, 8'd77, 8'd128, 8'd128, 1'b0});
    // gain above range acts as unity
    plan_cfg(REG_ALPHA_SCALE, 18'h1ff);
    plan_typed({8'd200, 8'd17, 8'd3, 8'd250, 1'b1}, {8'd200, 8'd17, 8'd3, 8'd250, 1'b1});
    plan_cfg(REG_ALPHA_SCALE, 18'd128);
    plan_typed({8'd255, 8'd10, 8'd20, 8'd30, 1'b0}, {8'd127, 8'd10, 8'd20, 8'd30, 1'b0});
    plan_cfg(REG_ALPHA_SCALE, CFG_DATA_W'(GAIN_UNITY));
    plan_cfg(REG_MODE, 18'd1);
    // luma just outside the default window keeps the pixel
    plan_typed({8'd180, 8'd27, 8'd55, 8'd35, 1'b0}, {8'd180, 8'd27, 8'd55, 8'd35, 1'b0});
    plan_typed({8'd180, 8'd229, 8'd55, 8'd35, 1'b1}, {8'd180, 8'd229, 8'd55, 8'd35, 1'b1});
    // key color, window edges, off-axis, neutral, opposite, chroma corners
    plan_pix({8'd255, 8'd128, 8'd55, 8'd35, 1'b0});
    plan_pix({8'd255, 8'd28, 8'd55, 8'd35, 1'b0});
    plan_pix({8'd255, 8'd228, 8'd55, 8'd35, 1'b1});
    plan_pix({8'd255, 8'd128, 8'd60, 8'd45, 1'b0});
    plan_pix({8'd255, 8'd128, 8'd128, 8'd128, 1'b0});
    plan_pix({8'd255, 8'd128, 8'd200, 8'd220, 1'b0});
    plan_pix({8'd255, 8'd128, 8'd0, 8'd0, 1'b0});
    plan_pix({8'd255, 8'd100, 8'd0, 8'd255, 1'b0});
    plan_pix({8'd255, 8'd100, 8'd255, 8'd0, 1'b1});
    // strongest alpha cut and spill, widest noise circle
    plan_cfg(REG_SUPPRESSION_GAINS, 18'hffff);
    plan_cfg(REG_NOISE_SQ, 18'h1fff);
    plan_pix({8'd255, 8'd200, 8'd55, 8'd35, 1'b0});
    plan_pix({8'd255, 8'd40, 8'd70, 8'd50, 1'b1});
    // no noise circle, steepest slopes
    plan_cfg(REG_NOISE_SQ, 18'd0);
    plan_cfg(REG_ANGLE_SLOPES, 18'hffff);
    plan_pix({8'd255, 8'd128, 8'd55, 8'd35, 1'b0});
    plan_pix({8'd128, 8'd128, 8'd80, 8'd40, 1'b0});
    // lowest keyed luma above highest: nothing is keyed
    plan_cfg(REG_LUMA_WINDOW, 18'd51400);
    plan_typed({8'd255, 8'd150, 8'd55, 8'd35, 1'b0}, {8'd255, 8'd150, 8'd55, 8'd35, 1'b0});
    // writes past the register map change nothing
    plan_cfg(IDX_UNUSED_LO, 18'd0);
    plan_cfg(IDX_UNUSED_HI, 18'h3ffff);
    plan_typed({8'd255, 8'd150, 8'd55, 8'd35, 1'b1}, {8'd255, 8'd150, 8'd55, 8'd35, 1'b1});

    // Hold reset, release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        maybe_gap();
        push_pixel(row.px, row.kind == ROW_TYPED, row.want);
      end
    end

    // Random phases, each under a fresh register setup; the last runs unthrottled
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == PHASES - 1) quiet = 1'b1;
      setup_phase(phase);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        maybe_gap();
        push_pixel(make_pixel(), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
